@@ sv/bilinear_half_quarter_downscaler_macros.svh @@
// Assertion macros for the bilinear half/quarter downscaler.
// Used by the top level; expects clk and rst in scope.
`ifndef BILINEAR_HALF_QUARTER_DOWNSCALER_MACROS_SVH
`define BILINEAR_HALF_QUARTER_DOWNSCALER_MACROS_SVH

// Implication within the same cycle.
`define BHQD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bhqd assertion failed");

// Consequent in the cycle after the antecedent.
`define BHQD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bhqd assertion failed");

`endif

@@ sv/bhqd_pkg.sv @@
// Shared constants and types of the bilinear half/quarter downscaler.
// No dependencies.
package bhqd_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 4096;
  localparam int FRAC_BITS   = 16;
  localparam int SAMPLE_BITS = 16;

  localparam logic [1:0] CFG_SRC_WIDTH   = 2'd0;
  localparam logic [1:0] CFG_SRC_HEIGHT  = 2'd1;
  localparam logic [1:0] CFG_PLANE_COUNT = 2'd2;

  localparam logic LVL_HALF    = 1'b0;
  localparam logic LVL_QUARTER = 1'b1;

  // One axis of an output pixel: near and far source index, far weight.
  typedef struct packed {
    logic [11:0] lo;
    logic [11:0] hi;
    logic [15:0] w;
  } coord_t;

endpackage

@@ sv/bhqd_in_if.sv @@
// Input channel of the downscaler: one source sample per transaction.
// Depends on bhqd_pkg.
interface bhqd_in_if import bhqd_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

@@ sv/bhqd_out_if.sv @@
// Result channel of the downscaler: one interpolated pixel per transaction.
// Depends on bhqd_pkg.
interface bhqd_out_if import bhqd_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic                          level;
  logic [10:0]                   out_row;
  logic [8:0]                    out_col;
  logic signed [SAMPLE_BITS-1:0] value;
  logic                          last_of_item;
  logic                          tensor_done;

  modport source (output valid, output level, output out_row, output out_col,
                  output value, output last_of_item, output tensor_done,
                  input ready);
  modport sink (input valid, input level, input out_row, input out_col,
                input value, input last_of_item, input tensor_done,
                output ready);
endinterface

@@ sv/bilinear_half_quarter_downscaler.sv @@
// Bilinear half/quarter downscaler: line memory, sequencer and datapath.
// Depends on bhqd_pkg, bhqd_in_if, bhqd_out_if and the assertion macros.
//
// pixel_in takes source samples in raster order, plane after plane.
// result_out gives the half-size (level 0) and quarter-size (level 1)
// pixels; each is issued on the sample that brings its bottom-right
// source neighbour, level 0 before level 1 when both fall on one sample.
// The configuration port (cfg_we, cfg_index, cfg_data) sets width, height
// and planes per tensor; write it only while the block is idle.
// Per item the sequencer reads the line memory (two read ports, registered
// outputs), updates it, runs the shared four-step interpolation datapath
// per result and then recomputes the next source coordinates.
// After reset, and after a configuration write outside an item, an
// iterative divider derives the four scale factors with pixel_in not ready.
// A stalled receiver holds the result register; the sequencer waits with
// the next result, and pixel_in stays not ready until the item is done.
// The line memory holds no reset value.
`include "bilinear_half_quarter_downscaler_macros.svh"

module bilinear_half_quarter_downscaler import bhqd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  bhqd_in_if.sink     pixel_in,
  bhqd_out_if.source  result_out
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_RD   = 11'b00000000010,
    S_QRD  = 11'b00000000100,
    S_M1   = 11'b00000001000,
    S_M2   = 11'b00000010000,
    S_M3   = 11'b00000100000,
    S_M4   = 11'b00001000000,
    S_UPD  = 11'b00010000000,
    S_C1   = 11'b00100000000,
    S_C2   = 11'b01000000000,
    S_DIV  = 11'b10000000000
  } state_t;

  state_t state;

  // configuration
  logic [10:0] cfg_w;
  logic [12:0] cfg_h;
  logic [15:0] cfg_pc;
  logic [10:0] w_eff;
  logic [12:0] h_eff;
  logic [15:0] pc_eff;
  logic [11:0] half_ho, quar_ho;
  logic [9:0]  half_wo;
  logic [8:0]  quar_wo;
  logic        cfg_restart;

  always_comb begin
    w_eff   = (cfg_w == 11'd0) ? 11'd1 : ((cfg_w > 11'(MAX_WIDTH)) ?
              11'(MAX_WIDTH) : cfg_w);
    h_eff   = (cfg_h == 13'd0) ? 13'd1 : ((cfg_h > 13'(MAX_HEIGHT)) ?
              13'(MAX_HEIGHT) : cfg_h);
    pc_eff  = (cfg_pc == 16'd0) ? 16'd1 : cfg_pc;
    half_ho = h_eff[12:1];
    quar_ho = {1'b0, h_eff[12:2]};
    half_wo = w_eff[10:1];
    quar_wo = w_eff[10:2];
  end

  // rescale on a write outside an item
  assign cfg_restart = cfg_we && (state == S_IDLE || state == S_DIV ||
                                  state == S_C1 || state == S_C2);

  // position state
  logic [9:0]  col_pos;
  logic [11:0] row_pos;
  logic [11:0] half_nr;
  logic [8:0]  half_nc;
  logic [10:0] quar_nr;
  logic [7:0]  quar_nc;
  logic [15:0] plane_counter;

  // scale factors: 0 half x, 1 half y, 2 quarter x, 3 quarter y
  logic [19:0] scale [4];
  logic [31:0] tpos [4];
  coord_t      crd [4];

  // divider
  logic [28:0] div_num;
  logic [11:0] div_rem;
  logic [19:0] div_quo;
  logic [4:0]  div_cnt;
  logic [1:0]  div_sel;
  logic        div_first;
  logic [12:0] div_src;
  logic [11:0] div_den;
  logic [12:0] div_rsh;
  logic        div_ge;
  logic [19:0] div_quo_next;

  always_comb begin
    case (div_sel)
      2'd0:    begin div_src = {2'b0, w_eff}; div_den = {2'b0, half_wo}; end
      2'd1:    begin div_src = h_eff;         div_den = half_ho;         end
      2'd2:    begin div_src = {2'b0, w_eff}; div_den = {3'b0, quar_wo}; end
      default: begin div_src = h_eff;         div_den = quar_ho;         end
    endcase
    div_rsh      = {div_rem, div_num[28]};
    div_ge       = div_rsh >= {1'b0, div_den};
    div_quo_next = {div_quo[18:0], div_ge};
  end

  // level status
  logic half_live, quar_live, half_done, quar_done;
  logic half_hit, quar_hit;

  always_comb begin
    half_done = (half_ho == 12'd0) || (half_wo == 10'd0) || (half_nr >= half_ho);
    quar_done = (quar_ho == 12'd0) || (quar_wo == 9'd0) || ({1'b0, quar_nr} >= quar_ho);
    half_live = !half_done && ({1'b0, half_nc} < half_wo);
    quar_live = !quar_done && ({1'b0, quar_nc} < quar_wo);
    half_hit  = half_live && (row_pos == crd[1].hi) && ({2'b0, col_pos} == crd[0].hi);
    quar_hit  = quar_live && (row_pos == crd[3].hi) && ({2'b0, col_pos} == crd[2].hi);
  end

  // item registers
  logic signed [15:0] sample_r, old_cur;
  logic signed [15:0] h_p0, h_c0, q_p0, q_c0;
  logic               h_trig, q_trig, qdone_before;
  logic               lvl;

  // line memory: {prev, cur} per column
  logic [31:0] line_mem [MAX_WIDTH];
  logic [9:0]  rd_addr_b;
  logic [31:0] rd_a, rd_b;
  logic        mem_we;

  assign rd_addr_b = (state == S_RD) ? crd[2].lo[9:0] : crd[0].lo[9:0];
  assign mem_we    = (state == S_RD);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[col_pos] <= {rd_a[15:0], sample_r};
    end
    rd_a <= line_mem[col_pos];
    rd_b <= line_mem[rd_addr_b];
  end

  // datapath
  logic signed [15:0] p0, c0, p1, c1;
  logic [15:0]        wx, wy;
  logic               yeq;
  logic signed [33:0] mx0, mx1;
  logic signed [33:0] a0, a1, base;
  logic signed [34:0] dlt;
  logic signed [34:0] base_r;
  logic signed [51:0] prod;
  logic signed [51:0] acc;
  logic signed [15:0] q_val;

  assign p1 = old_cur;
  assign c1 = sample_r;

  always_comb begin
    p0  = (lvl == LVL_QUARTER) ? q_p0 : h_p0;
    c0  = (lvl == LVL_QUARTER) ? q_c0 : h_c0;
    wx  = (lvl == LVL_QUARTER) ? crd[2].w : crd[0].w;
    wy  = (lvl == LVL_QUARTER) ? crd[3].w : crd[1].w;
    yeq = (lvl == LVL_QUARTER) ? (crd[3].lo == crd[3].hi) : (crd[1].lo == crd[1].hi);
    a0   = ($signed({{18{p0[15]}}, p0}) <<< FRAC_BITS) + mx0;
    a1   = ($signed({{18{c0[15]}}, c0}) <<< FRAC_BITS) + mx1;
    base = yeq ? a1 : a0;
    acc  = ($signed({{18{base_r[33]}}, base_r[33:0]}) <<< FRAC_BITS) + prod;
    q_val = 16'((acc + 52'sd2147483648) >>> (2 * FRAC_BITS));
  end

  // per-level counter updates
  logic [11:0] half_nr_next;
  logic [8:0]  half_nc_next;
  logic [10:0] quar_nr_next;
  logic [7:0]  quar_nc_next;
  logic        last_plane;

  always_comb begin
    if ({1'b0, half_nc} + 10'd1 >= half_wo) begin
      half_nc_next = 9'd0;
      half_nr_next = half_nr + 12'd1;
    end else begin
      half_nc_next = half_nc + 9'd1;
      half_nr_next = half_nr;
    end
    if ({1'b0, quar_nc} + 9'd1 >= quar_wo) begin
      quar_nc_next = 8'd0;
      quar_nr_next = quar_nr + 11'd1;
    end else begin
      quar_nc_next = quar_nc + 8'd1;
      quar_nr_next = quar_nr;
    end
    last_plane = ({1'b0, plane_counter} + 17'd1) >= {1'b0, pc_eff};
  end

  // output register
  logic out_load;
  assign out_load = (state == S_M4) && (!result_out.valid || result_out.ready);

  assign pixel_in.ready = (state == S_IDLE) && !cfg_we;

  function automatic coord_t map_axis(input logic [31:0] t, input logic [12:0] src);
    logic [31:0] tm;
    logic [14:0] l;
    logic [12:0] srcm1;
    coord_t      c;
    tm    = t - 32'(1 << FRAC_BITS);
    l     = tm[31:17];
    srcm1 = src - 13'd1;
    c.lo  = ({1'b0, l} > {3'b0, srcm1}) ? srcm1[11:0] : l[11:0];
    c.hi  = (({1'b0, c.lo} + 13'd1) < src) ? (c.lo + 12'd1) : c.lo;
    c.w   = tm[16:1];
    return c;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_DIV;
      cfg_w           <= 11'd1024;
      cfg_h           <= 13'd1024;
      cfg_pc          <= 16'd1;
      col_pos         <= '0;
      row_pos         <= '0;
      half_nr         <= '0;
      half_nc         <= '0;
      quar_nr         <= '0;
      quar_nc         <= '0;
      plane_counter   <= '0;
      div_sel         <= '0;
      div_first       <= 1'b1;
      div_cnt         <= '0;
      result_out.valid <= 1'b0;
    end else begin
      if (out_load) begin
        result_out.valid <= 1'b1;
      end else if (result_out.ready) begin
        result_out.valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_SRC_WIDTH:   cfg_w  <= cfg_data[10:0];
          CFG_SRC_HEIGHT:  cfg_h  <= cfg_data[12:0];
          CFG_PLANE_COUNT: cfg_pc <= cfg_data;
          default: ;
        endcase
      end
      if (cfg_restart) begin
        div_sel   <= '0;
        div_first <= 1'b1;
        state     <= S_DIV;
      end else begin
        case (state)
          S_IDLE: begin
            if (pixel_in.valid) begin
              sample_r     <= pixel_in.sample;
              h_trig       <= half_hit;
              q_trig       <= quar_hit;
              qdone_before <= quar_done;
              state        <= S_RD;
            end
          end
          S_RD: begin
            // taps at the near column see the store after this update
            old_cur <= rd_a[15:0];
            if (crd[0].lo[9:0] == col_pos) begin
              h_p0 <= rd_a[15:0];
              h_c0 <= sample_r;
            end else begin
              h_p0 <= rd_b[31:16];
              h_c0 <= rd_b[15:0];
            end
            state <= S_QRD;
          end
          S_QRD: begin
            if (crd[2].lo[9:0] == col_pos) begin
              q_p0 <= old_cur;
              q_c0 <= sample_r;
            end else begin
              q_p0 <= rd_b[31:16];
              q_c0 <= rd_b[15:0];
            end
            if (h_trig) begin
              lvl   <= LVL_HALF;
              state <= S_M1;
            end else if (q_trig) begin
              lvl   <= LVL_QUARTER;
              state <= S_M1;
            end else begin
              state <= S_UPD;
            end
          end
          S_M1: begin
            mx0   <= $signed({18'b0, wx}) * $signed(34'(p1) - 34'(p0));
            mx1   <= $signed({18'b0, wx}) * $signed(34'(c1) - 34'(c0));
            state <= S_M2;
          end
          S_M2: begin
            base_r <= 35'(base);
            dlt    <= yeq ? 35'sd0 : (35'(a1) - 35'(a0));
            state  <= S_M3;
          end
          S_M3: begin
            prod  <= $signed({36'b0, wy}) * $signed(52'(dlt));
            state <= S_M4;
          end
          S_M4: begin
            if (out_load) begin
              result_out.level <= lvl;
              result_out.value <= q_val;
              if (lvl == LVL_HALF) begin
                result_out.out_row      <= half_nr[10:0];
                result_out.out_col      <= half_nc;
                result_out.last_of_item <= !q_trig;
                result_out.tensor_done  <= last_plane && qdone_before &&
                                           (half_nr_next >= half_ho);
                half_nr <= half_nr_next;
                half_nc <= half_nc_next;
              end else begin
                result_out.out_row      <= quar_nr;
                result_out.out_col      <= {1'b0, quar_nc};
                result_out.last_of_item <= 1'b1;
                result_out.tensor_done  <= last_plane && half_done &&
                                           ({1'b0, quar_nr_next} >= quar_ho);
                quar_nr <= quar_nr_next;
                quar_nc <= quar_nc_next;
              end
              if (lvl == LVL_HALF && q_trig) begin
                lvl   <= LVL_QUARTER;
                state <= S_M1;
              end else begin
                state <= S_UPD;
              end
            end
          end
          S_UPD: begin
            if ({1'b0, col_pos} + 11'd1 >= w_eff) begin
              col_pos <= '0;
              if ({1'b0, row_pos} + 13'd1 >= h_eff) begin
                row_pos <= '0;
                half_nr <= '0;
                half_nc <= '0;
                quar_nr <= '0;
                quar_nc <= '0;
                plane_counter <= last_plane ? 16'd0 : plane_counter + 16'd1;
              end else begin
                row_pos <= row_pos + 12'd1;
              end
            end else begin
              col_pos <= col_pos + 10'd1;
            end
            state <= S_C1;
          end
          S_C1: begin
            tpos[0] <= 32'({half_nc, 1'b1}) * 32'(scale[0]);
            tpos[1] <= 32'({half_nr, 1'b1}) * 32'(scale[1]);
            tpos[2] <= 32'({quar_nc, 1'b1}) * 32'(scale[2]);
            tpos[3] <= 32'({quar_nr, 1'b1}) * 32'(scale[3]);
            state   <= S_C2;
          end
          S_C2: begin
            crd[0] <= map_axis(tpos[0], {2'b0, w_eff});
            crd[1] <= map_axis(tpos[1], h_eff);
            crd[2] <= map_axis(tpos[2], {2'b0, w_eff});
            crd[3] <= map_axis(tpos[3], h_eff);
            state  <= S_IDLE;
          end
          S_DIV: begin
            if (div_first) begin
              div_num   <= {div_src, 16'b0} + 29'(div_den >> 1);
              div_rem   <= '0;
              div_quo   <= '0;
              div_cnt   <= '0;
              div_first <= 1'b0;
            end else begin
              div_rem <= div_ge ? 12'(div_rsh - {1'b0, div_den}) : div_rsh[11:0];
              div_quo <= div_quo_next;
              div_num <= {div_num[27:0], 1'b0};
              div_cnt <= div_cnt + 5'd1;
              if (div_cnt == 5'd28) begin
                scale[div_sel] <= div_quo_next;
                div_first      <= 1'b1;
                if (div_sel == 2'd3) begin
                  state <= S_C1;
                end else begin
                  div_sel <= div_sel + 2'd1;
                end
              end
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  `BHQD_ASSERT_NEXT(a_accept_reads, pixel_in.valid && pixel_in.ready, state == S_RD)
  `BHQD_ASSERT(a_load_free, out_load |-> (!result_out.valid || result_out.ready))
  `BHQD_ASSERT_NEXT(a_cfg_rescale, cfg_we && state == S_IDLE, state == S_DIV)
  `BHQD_ASSERT_NEXT(a_quarter_last, out_load && lvl == LVL_QUARTER,
                    result_out.valid && result_out.last_of_item)

endmodule

@@ dv/bilinear_half_quarter_downscaler_test.sv @@
// Self-checking testbench of the bilinear half/quarter downscaler.
// Depends on bhqd_pkg, bhqd_in_if, bhqd_out_if and the downscaler top level.
// A directed table, then random planes of random sizes, against a built-in predictor.
module bilinear_half_quarter_downscaler_test;
  import bhqd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 3000000;
  localparam int     SETTLE = 24;

  typedef struct {
    logic        level;
    logic [10:0] out_row;
    logic [8:0]  out_col;
    logic [15:0] value;
    logic        last_of_item;
    logic        tensor_done;
  } pixel_result_t;

  typedef struct {
    int          w;
    int          h;
    logic [15:0] sample;
    bit          typed;
    logic [15:0] value;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_SRC_WIDTH;
  logic [15:0] cfg_data = '0;

  bhqd_in_if  pin ();
  bhqd_out_if rout ();

  bilinear_half_quarter_downscaler dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .pixel_in(pin.sink), .result_out(rout.source)
  );

  pixel_result_t pending_pixels[$];
  int            fail_count = 0;
  longint        cycle_count = 0;
  bit            hold_request = 1'b0;

  // Predictor state.
  longint      prev_line[MAX_WIDTH];
  longint      cur_line[MAX_WIDTH];
  int unsigned col_at, row_at, half_row, half_col, qtr_row, qtr_col, planes_seen;
  logic [10:0] width_reg = 11'd1024;
  logic [12:0] height_reg = 13'd1024;
  logic [15:0] planes_reg = 16'd1;

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic void map_axis(input int unsigned d, input int unsigned src,
                                   input int unsigned dst, output int unsigned lo,
                                   output int unsigned hi, output longint w);
    longint unsigned one, scale, s, l;
    one = 64'd1 << FRAC_BITS;
    scale = ((longint'(src) << FRAC_BITS) + dst / 2) / dst;
    s = ((2 * longint'(d) + 1) * scale - one) >> 1;
    l = s >> FRAC_BITS;
    if (l > src - 1) l = src - 1;
    lo = 32'(l);
    hi = (l + 1 < src) ? 32'(l + 1) : 32'(l);
    w = longint'(s & (one - 1));
  endfunction

  function automatic bit level_finished(int unsigned div, int unsigned nr,
                                        int unsigned w, int unsigned h);
    return (h / div == 0) || (w / div == 0) || (nr >= h / div);
  endfunction

  // Interpolate the next pending pixel of one level if this sample triggers it.
  function automatic bit interpolate_level(input logic lvl, input int unsigned div,
                                           inout int unsigned nr, inout int unsigned nc,
                                           input int unsigned w, input int unsigned h,
                                           output pixel_result_t r);
    int unsigned ho, wo, y0, y1, x0, x1;
    longint wy, wx, one, a0, a1, acc;
    ho = h / div;
    wo = w / div;
    r = '{default: '0};
    if (ho == 0 || wo == 0 || nr >= ho || nc >= wo) return 0;
    map_axis(nr, h, ho, y0, y1, wy);
    map_axis(nc, w, wo, x0, x1, wx);
    if (row_at != y1 || col_at != x1) return 0;
    one = 64'sd1 << FRAC_BITS;
    a0 = (one - wx) * prev_line[x0] + wx * prev_line[x1];
    a1 = (one - wx) * cur_line[x0] + wx * cur_line[x1];
    if (y0 == y1) a0 = a1;
    acc = (one - wy) * a0 + wy * a1 + (64'sd1 <<< (2 * FRAC_BITS - 1));
    r.level = lvl;
    r.out_row = nr[10:0];
    r.out_col = nc[8:0];
    r.value = 16'(acc >>> (2 * FRAC_BITS));
    nc++;
    if (nc >= wo) begin
      nc = 0;
      nr++;
    end
    return 1;
  endfunction

  function automatic int downscale_sample(logic [15:0] s, output pixel_result_t res[2]);
    int unsigned w, h, pc;
    bit          last_plane, qdone_before;
    int          n;
    w = width_reg;
    h = height_reg;
    pc = (planes_reg == 0) ? 1 : planes_reg;
    if (w < 1) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (h < 1) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    n = 0;
    if (col_at < MAX_WIDTH) begin
      prev_line[col_at] = cur_line[col_at];
      cur_line[col_at] = longint'($signed(s));
    end
    last_plane = planes_seen + 1 >= pc;
    qdone_before = level_finished(4, qtr_row, w, h);
    if (interpolate_level(LVL_HALF, 2, half_row, half_col, w, h, res[0])) begin
      res[0].tensor_done = last_plane && qdone_before && level_finished(2, half_row, w, h);
      n = 1;
    end
    if (interpolate_level(LVL_QUARTER, 4, qtr_row, qtr_col, w, h, res[n])) begin
      res[n].tensor_done = last_plane && level_finished(2, half_row, w, h)
                           && level_finished(4, qtr_row, w, h);
      n++;
    end
    if (n > 0) res[n-1].last_of_item = 1'b1;
    col_at++;
    if (col_at >= w) begin
      col_at = 0;
      row_at++;
      if (row_at >= h) begin
        row_at = 0;
        half_row = 0; half_col = 0; qtr_row = 0; qtr_col = 0;
        planes_seen++;
        if (planes_seen >= pc) planes_seen = 0;
      end
    end
    return n;
  endfunction

  // Offer one sample from a falling edge; return at the falling edge after the transaction.
  task automatic send_sample(logic [15:0] s, bit typed = 1'b0, logic [15:0] typed_value = '0);
    pixel_result_t res[2];
    int            n;
    pin.valid <= 1'b1;
    pin.sample <= s;
    do @(posedge clk); while (!(pin.valid && pin.ready));
    n = downscale_sample(s, res);
    if (typed && n > 0) res[0].value = typed_value;
    for (int i = 0; i < n; i++) pending_pixels.push_back(res[i]);
    @(negedge clk);
  endtask

  task automatic idle_sender(int cycles);
    pin.valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic drain;
    idle_sender(1);
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SRC_WIDTH:   width_reg = data[10:0];
      CFG_SRC_HEIGHT:  height_reg = data[12:0];
      CFG_PLANE_COUNT: planes_reg = data;
      default: ;
    endcase
  endtask

  task automatic configure(int w, int h, int p);
    drain();
    write_reg(CFG_SRC_WIDTH, 16'(w));
    write_reg(CFG_SRC_HEIGHT, 16'(h));
    write_reg(CFG_PLANE_COUNT, 16'(p));
    @(negedge clk);
  endtask

  // Whole planes with bursty offers; one in eight planes waits for the results to drain first.
  task automatic send_planes(int planes, bit narrow_values);
    int unsigned w, h, burst;
    logic [15:0] s;
    w = (width_reg < 1) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    h = (height_reg < 1) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    burst = $urandom_range(1, 40);
    for (int p = 0; p < planes; p++) begin
      if ($urandom_range(0, 7) == 0) begin
        idle_sender(1);
        while (pending_pixels.size() != 0) @(negedge clk);
      end
      for (int i = 0; i < w * h; i++) begin
        s = narrow_values ? 16'($urandom_range(0, 200) - 100) : 16'($urandom);
        send_sample(s);
        if (--burst == 0) begin
          if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 12));
          burst = $urandom_range(1, 40);
        end
      end
    end
  endtask

  // Receiver: switches between random stall patterns; a hold request holds ready low, then is cleared.
  initial begin
    int mode;
    rout.ready = 1'b0;
    mode = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        rout.ready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_request = 1'b0;
      end
      if (cycle_count % 64 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: rout.ready <= 1'b1;
        1: rout.ready <= ($urandom_range(0, 1) == 1);
        2: rout.ready <= ($urandom_range(0, 4) == 0);
        default: rout.ready <= (cycle_count % 7 != 3);
      endcase
    end
  end

  always @(posedge clk) begin
    pixel_result_t e;
    if (!rst && rout.valid && rout.ready) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected result level=%0d row=%0d col=%0d", rout.level, rout.out_row,
               rout.out_col);
        fail_count++;
      end else begin
        e = pending_pixels.pop_front();
        if (rout.level !== e.level) begin
          $error("level: expected %0d, got %0d", e.level, rout.level); fail_count++;
        end
        if (rout.out_row !== e.out_row) begin
          $error("out_row: expected %0d, got %0d", e.out_row, rout.out_row); fail_count++;
        end
        if (rout.out_col !== e.out_col) begin
          $error("out_col: expected %0d, got %0d", e.out_col, rout.out_col); fail_count++;
        end
        if (rout.value !== e.value) begin
          $error("value: expected %0d, got %0d", $signed(e.value), $signed(rout.value));
          fail_count++;
        end
        if (rout.last_of_item !== e.last_of_item) begin
          $error("last_of_item: expected %0d, got %0d", e.last_of_item, rout.last_of_item);
          fail_count++;
        end
        if (rout.tensor_done !== e.tensor_done) begin
          $error("tensor_done: expected %0d, got %0d", e.tensor_done, rout.tensor_done);
          fail_count++;
        end
      end
    end
  end

  directed_row_t directed[] = '{
    '{2, 2, 16'h7fff, 0, 0}, '{2, 2, 16'h7fff, 0, 0},
    '{2, 2, 16'h7fff, 0, 0}, '{2, 2, 16'h7fff, 1, 16'h7fff},
    '{2, 2, 16'h8000, 0, 0}, '{2, 2, 16'h8000, 0, 0},
    '{2, 2, 16'h8000, 0, 0}, '{2, 2, 16'h8000, 1, 16'h8000},
    // tie on the positive side rounds up: 2.5 -> 3, and -2.5 -> -2
    '{2, 2, 16'd1, 0, 0}, '{2, 2, 16'd2, 0, 0}, '{2, 2, 16'd3, 0, 0}, '{2, 2, 16'd4, 1, 16'd3},
    '{2, 2, -16'sd1, 0, 0}, '{2, 2, -16'sd2, 0, 0},
    '{2, 2, -16'sd3, 0, 0}, '{2, 2, -16'sd4, 1, -16'sd2},
    '{4, 4, 16'h7fff, 0, 0}, '{4, 4, 16'h8000, 0, 0}, '{4, 4, 16'h1234, 0, 0},
    '{4, 4, 16'hedcb, 0, 0}, '{4, 4, 16'h0000, 0, 0}, '{4, 4, 16'hffff, 0, 0},
    '{4, 4, 16'h5555, 0, 0}, '{4, 4, 16'haaaa, 0, 0}, '{4, 4, 16'h0001, 0, 0},
    '{4, 4, 16'h8001, 0, 0}, '{4, 4, 16'h7ffe, 0, 0}, '{4, 4, 16'h00ff, 0, 0},
    '{4, 4, 16'hff00, 0, 0}, '{4, 4, 16'h7fff, 0, 0}, '{4, 4, 16'h7fff, 0, 0},
    '{4, 4, 16'h8000, 0, 0}
  };

  initial begin
    pin.valid = 1'b0;
    pin.sample = '0;
    foreach (prev_line[i]) begin
      prev_line[i] = 0;
      cur_line[i] = 0;
    end
    {col_at, row_at, half_row, half_col, qtr_row, qtr_col, planes_seen} = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed[i]) begin
      if (directed[i].w != width_reg || directed[i].h != height_reg)
        configure(directed[i].w, directed[i].h, 1);
      send_sample(directed[i].sample, directed[i].typed, directed[i].value);
    end

    // Clamped register values.
    configure(0, 0, 0);
    send_planes(2, 0);
    configure(2, 2, 65535);
    send_planes(3, 0);

    // Random sizes; the receiver is held off once while offers keep coming.
    for (int ph = 0; ph < 8; ph++) begin
      configure($urandom_range(2, 12), $urandom_range(2, 12), $urandom_range(1, 3));
      if (ph == 3) hold_request = 1'b1;
      send_planes($urandom_range(1, 3), $urandom_range(0, 1));
    end

    drain();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
